// ----- rtl/ffsa_pkg.sv -----
// shared constants for the first-fit segment allocator
package ffsa_pkg;
	localparam int POOL_BYTES_DEF   = 1024;
	localparam int MAX_SEGMENTS_DEF = 64;
	localparam logic [31:0] BASE_RESET   = 32'h0020_0000;
	localparam logic [7:0]  HEADER_RESET = 8'd24;

	localparam logic [0:0] OP_ALLOC   = 1'b0;
	localparam logic [0:0] OP_RELEASE = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOMEM   = 2'd1;
	localparam logic [1:0] ST_NOMATCH = 2'd2;

	localparam int CFG_BASE   = 0;
	localparam int CFG_HEADER = 1;
endpackage

// ----- rtl/ffsa_if.sv -----
// valid/ready channel interfaces for requests, results and configuration
interface ffsa_req_if;
	logic        valid;
	logic        ready;
	logic [0:0]  operation;
	logic [15:0] request_size;
	logic [31:0] release_address;
	modport source (output valid, operation, request_size, release_address, input ready);
	modport sink (input valid, operation, request_size, release_address, output ready);
endinterface

interface ffsa_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] granted_address;
	logic [1:0]  status;
	modport source (output valid, granted_address, status, input ready);
	modport sink (input valid, granted_address, status, output ready);
endinterface

interface ffsa_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/ffsa_ram.sv -----
// generic ram with one write port and one registered read port
module ffsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/first_fit_segment_allocator.sv -----
// Top level: first-fit segment allocator with split and coalesce.
// Channels: req (operation, request_size, release_address), rsp
// (granted_address, status), cfg (index 0 base_address, 1 header_bytes).
// Segment records (offset, size, next, free) lie in one ram with one
// write port and one registered read port. An allocate walks up to
// MAX_SEGMENTS entries; a split adds a free-slot search over up to
// MAX_SEGMENTS slots and the writes in SWR and CWR. A release walks to
// the match and then runs a merge walk from the head, each step going
// through MRD, MNX and MCHK. A release of address zero is answered
// straight from IDLE.
// One request is worked on at a time; the result sits in an output
// register, and a stalled receiver only holds it there while the block
// waits to take the next request after the beat leaves.
// Reset and any config write restore one free segment. Used and
// has-next bits sit in flip-flops, so no ram clearing pass is needed.
// Config writes are taken only when the block is idle and no result is pending.
module first_fit_segment_allocator #(
	parameter int POOL_BYTES   = ffsa_pkg::POOL_BYTES_DEF,
	parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	ffsa_req_if.sink   req,
	ffsa_rsp_if.source rsp,
	ffsa_cfg_if.sink   cfg
);
	localparam int IW = $clog2(MAX_SEGMENTS);
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam int SW = $clog2(2 * MAX_SEGMENTS + 1);
	localparam int RW = 16 + 16 + IW + 1;

	typedef enum logic [3:0] {
		IDLE, CWR, ACHK, SRCH, SWR, RRD, RCHK, MRD, MNX, MCHK, DONE
	} state_t;

	typedef struct packed {
		logic [15:0]   off;
		logic [15:0]   size;
		logic [IW-1:0] nxt;
		logic          free;
	} rec_t;

	state_t          state_q;
	logic [31:0]     base_q;
	logic [7:0]      hdr_q;
	logic [MAX_SEGMENTS-1:0] used_q, hasn_q;
	logic [CW-1:0]   count_q;
	logic [IW-1:0]   cur_q, new_q;
	logic [SW-1:0]   steps_q;
	logic [15:0]     req_q;
	logic [31:0]     addr_q;
	rec_t            cur_rec_q;
	logic            out_v_q;
	logic [31:0]     out_a_q;
	logic [1:0]      out_s_q;

	logic            we;
	logic [IW-1:0]   waddr, raddr;
	rec_t            wrec, rrec;
	logic [RW-1:0]   rdata;

	assign rrec = rec_t'(rdata);

	ffsa_ram #(.WIDTH(RW), .DEPTH(MAX_SEGMENTS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(RW'(wrec)),
		.raddr(raddr), .rdata(rdata)
	);

	logic [15:0] h16;
	logic [7:0]  hdr_new;
	logic [15:0] h16_new;
	logic [31:0] paddr;
	logic [16:0] split_lim;
	logic [16:0] pool_sz;
	assign h16 = (hdr_q == 8'd0) ? 16'd1 : {8'd0, hdr_q};
	// header in force once the pending config beat lands
	assign hdr_new = (arst_n && cfg.valid && cfg.index == 32'(ffsa_pkg::CFG_HEADER)) ?
		cfg.data[7:0] : hdr_q;
	assign h16_new = (hdr_new == 8'd0) ? 16'd1 : {8'd0, hdr_new};
	assign paddr = base_q + {16'd0, rrec.off} + {16'd0, h16};
	assign split_lim = {1'b0, req_q} + {1'b0, h16};
	assign pool_sz = (32'(h16_new) >= 32'(POOL_BYTES)) ? 17'd0 :
		17'(POOL_BYTES) - {1'b0, h16_new};

	assign req.ready = (state_q == IDLE) && !out_v_q && !cfg.valid;
	assign cfg.ready = (state_q == IDLE) && !out_v_q;
	assign rsp.valid = out_v_q;
	assign rsp.granted_address = out_a_q;
	assign rsp.status = out_s_q;

	// ram port control
	always_comb begin
		we = 1'b0;
		waddr = cur_q;
		wrec = cur_rec_q;
		raddr = cur_q;
		case (state_q)
			IDLE: begin
				if ((cfg.valid && cfg.ready) || !arst_n) begin
					we = 1'b1;
					waddr = '0;
					wrec = '{off: 16'd0, size: pool_sz[15:0], nxt: '0, free: 1'b1};
				end
				raddr = '0;
			end
			ACHK: begin
				if (used_q[cur_q] && rrec.free && rrec.size >= req_q) begin
					if (!({1'b0, rrec.size} > split_lim && 32'(count_q) < 32'(MAX_SEGMENTS))) begin
						we = 1'b1;
						wrec = rrec;
						wrec.free = 1'b0;
					end
				end
				raddr = rrec.nxt;
			end
			SWR: begin
				we = 1'b1;
				waddr = new_q;
				wrec = '{off: cur_rec_q.off + h16 + req_q,
					size: cur_rec_q.size - req_q - h16,
					nxt: cur_rec_q.nxt, free: 1'b1};
			end
			CWR: begin
				we = 1'b1;
			end
			RCHK: begin
				if (used_q[cur_q] && paddr == addr_q) begin
					we = 1'b1;
					wrec = rrec;
					wrec.free = 1'b1;
				end
				raddr = rrec.nxt;
			end
			MRD: raddr = cur_q;
			MNX: raddr = rrec.nxt;
			MCHK: begin
				raddr = cur_q;
				if (cur_rec_q.free && rrec.free) begin
					we = 1'b1;
					wrec = cur_rec_q;
					wrec.size = cur_rec_q.size + rrec.size + h16;
					wrec.nxt = rrec.nxt;
				end
			end
			default: ;
		endcase
	end

	// sequencer, pool state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			base_q <= ffsa_pkg::BASE_RESET;
			hdr_q <= ffsa_pkg::HEADER_RESET;
			used_q <= MAX_SEGMENTS'(1);
			hasn_q <= '0;
			count_q <= CW'(1);
			out_v_q <= 1'b0;
			out_a_q <= '0;
			out_s_q <= '0;
			req_q <= '0;
			addr_q <= '0;
			cur_rec_q <= '0;
			cur_q <= '0;
			new_q <= '0;
			steps_q <= '0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (cfg.valid && cfg.ready) begin
						if (cfg.index == 32'(ffsa_pkg::CFG_BASE)) base_q <= cfg.data;
						else if (cfg.index == 32'(ffsa_pkg::CFG_HEADER)) hdr_q <= cfg.data[7:0];
						used_q <= MAX_SEGMENTS'(1);
						hasn_q <= '0;
						count_q <= CW'(1);
					end else if (req.valid && req.ready) begin
						req_q <= req.request_size;
						addr_q <= req.release_address;
						cur_q <= '0;
						steps_q <= '0;
						if (req.operation == ffsa_pkg::OP_ALLOC) begin
							state_q <= ACHK;
						end else if (req.release_address == 32'd0) begin
							out_a_q <= 32'd0;
							out_s_q <= ffsa_pkg::ST_OK;
							out_v_q <= 1'b1;
						end else begin
							state_q <= RCHK;
						end
					end
				end
				ACHK: begin
					cur_rec_q <= rrec;
					if (used_q[cur_q] && rrec.free && rrec.size >= req_q) begin
						out_a_q <= paddr;
						out_s_q <= ffsa_pkg::ST_OK;
						if ({1'b0, rrec.size} > split_lim && 32'(count_q) < 32'(MAX_SEGMENTS)) begin
							new_q <= '0;
							state_q <= SRCH;
						end else begin
							state_q <= DONE;
						end
					end else if (!hasn_q[cur_q] || 32'(steps_q) == 32'(MAX_SEGMENTS - 1)) begin
						out_a_q <= 32'd0;
						out_s_q <= ffsa_pkg::ST_NOMEM;
						state_q <= DONE;
					end else begin
						cur_q <= rrec.nxt;
						steps_q <= steps_q + SW'(1);
					end
				end
				SRCH: begin
					if (!used_q[new_q]) state_q <= SWR;
					else new_q <= new_q + IW'(1);
				end
				SWR: begin
					used_q[new_q] <= 1'b1;
					hasn_q[new_q] <= hasn_q[cur_q];
					hasn_q[cur_q] <= 1'b1;
					count_q <= count_q + CW'(1);
					cur_rec_q.nxt <= new_q;
					cur_rec_q.size <= req_q;
					cur_rec_q.free <= 1'b0;
					state_q <= CWR;
				end
				// write back the shortened granted segment
				CWR: state_q <= DONE;
				RRD: state_q <= RCHK;
				RCHK: begin
					if (used_q[cur_q] && paddr == addr_q) begin
						out_a_q <= 32'd0;
						out_s_q <= ffsa_pkg::ST_OK;
						cur_q <= '0;
						steps_q <= '0;
						state_q <= MRD;
					end else if (!hasn_q[cur_q] || 32'(steps_q) == 32'(MAX_SEGMENTS - 1)) begin
						out_a_q <= 32'd0;
						out_s_q <= ffsa_pkg::ST_NOMATCH;
						state_q <= DONE;
					end else begin
						cur_q <= rrec.nxt;
						steps_q <= steps_q + SW'(1);
					end
				end
				MRD: state_q <= MNX;
				MNX: begin
					cur_rec_q <= rrec;
					if (!hasn_q[cur_q] || 32'(steps_q) >= 32'(2 * MAX_SEGMENTS)) begin
						state_q <= DONE;
					end else begin
						new_q <= rrec.nxt;
						state_q <= MCHK;
					end
				end
				MCHK: begin
					steps_q <= steps_q + SW'(1);
					if (cur_rec_q.free && rrec.free) begin
						hasn_q[cur_q] <= hasn_q[new_q];
						used_q[new_q] <= 1'b0;
						hasn_q[new_q] <= 1'b0;
						if (count_q != '0) count_q <= count_q - CW'(1);
					end else begin
						cur_q <= new_q;
					end
					state_q <= MRD;
				end
				DONE: begin
					out_v_q <= 1'b1;
					state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// a result is never overwritten while it waits
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.granted_address))
		else $error("result changed while stalled");
	// no request taken while a result is pending
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !req.ready)
		else $error("request accepted with result pending");
	// head segment always live
	a_head: assert property (@(posedge clk) disable iff (!arst_n)
		used_q[0] && count_q != '0)
		else $error("head segment lost");
`endif
endmodule

// ----- tb/tb_first_fit_segment_allocator.sv -----
// testbench for the first-fit segment allocator: directed table, then random traffic
`timescale 1ns / 100ps

module tb_first_fit_segment_allocator;

	localparam int NUM_SEGS     = ffsa_pkg::MAX_SEGMENTS_DEF;
	localparam int POOL         = ffsa_pkg::POOL_BYTES_DEF;
	localparam int CFG_UNLISTED = 2;
	localparam int STALL_LIMIT  = 20000;
	localparam int DRAIN_CYCLES = 6 * NUM_SEGS + 16;
	localparam int PHASE_ITEMS  = 215;

	typedef struct packed {
		logic [31:0] granted_address;
		logic [1:0]  status;
	} alloc_result_t;

	typedef struct packed {
		logic [0:0]  operation;
		logic [15:0] request_size;
		logic [31:0] release_address;
		logic        typed;
		logic [31:0] granted_address;
		logic [1:0]  status;
	} table_row_t;

	logic clk;
	logic arst_n;

	ffsa_req_if req_ch ();
	ffsa_rsp_if rsp_ch ();
	ffsa_cfg_if cfg_ch ();

	first_fit_segment_allocator DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// pool image kept by the predictor
	logic [31:0] pool_base;
	logic [7:0]  pool_header;
	logic [15:0] seg_size   [NUM_SEGS];
	logic [15:0] seg_offset [NUM_SEGS];
	logic [5:0]  seg_next   [NUM_SEGS];
	logic        seg_free   [NUM_SEGS];
	logic        seg_used   [NUM_SEGS];
	logic        seg_linked [NUM_SEGS];
	int          seg_count;

	alloc_result_t pending_results[$];
	logic [31:0]   held_addresses[$];
	logic [31:0]   freed_addresses[$];
	int            error_count;
	int            quiet_cycles;
	bit            steady_mode;

	// clock and reset
	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	function automatic int header_len();
		return (pool_header == 8'd0) ? 1 : int'(pool_header);
	endfunction

	function automatic logic [31:0] payload_of(int idx);
		return pool_base + 32'(seg_offset[idx]) + 32'(header_len());
	endfunction

	function automatic void restore_single_segment();
		int h;
		h = header_len();
		for (int i = 0; i < NUM_SEGS; i++) begin
			seg_size[i]   = '0;
			seg_offset[i] = '0;
			seg_next[i]   = '0;
			seg_free[i]   = 1'b0;
			seg_used[i]   = 1'b0;
			seg_linked[i] = 1'b0;
		end
		seg_size[0] = (h >= POOL) ? 16'd0 : 16'(POOL - h);
		seg_free[0] = 1'b1;
		seg_used[0] = 1'b1;
		seg_count   = 1;
	endfunction

	function automatic void apply_register(int index, logic [31:0] value);
		if (index == ffsa_pkg::CFG_BASE)
			pool_base = value;
		else if (index == ffsa_pkg::CFG_HEADER)
			pool_header = value[7:0];
		restore_single_segment();
	endfunction

	// first fit with optional split
	function automatic alloc_result_t allocate_segment(logic [15:0] want);
		alloc_result_t r;
		int cur, h, n;
		cur = 0;
		h   = header_len();
		r.granted_address = '0;
		r.status          = ffsa_pkg::ST_NOMEM;
		for (int steps = 0; steps < NUM_SEGS; steps++) begin
			if (seg_used[cur] && seg_free[cur] && seg_size[cur] >= want) begin
				if (int'(seg_size[cur]) > int'(want) + h && seg_count < NUM_SEGS) begin
					n = 0;
					while (n < NUM_SEGS && seg_used[n]) n++;
					if (n < NUM_SEGS) begin
						seg_used[n]   = 1'b1;
						seg_free[n]   = 1'b1;
						seg_offset[n] = 16'(int'(seg_offset[cur]) + h + int'(want));
						seg_size[n]   = 16'(int'(seg_size[cur]) - int'(want) - h);
						seg_next[n]   = seg_next[cur];
						seg_linked[n] = seg_linked[cur];
						seg_next[cur]   = 6'(n);
						seg_linked[cur] = 1'b1;
						seg_size[cur]   = want;
						seg_count++;
					end
				end
				seg_free[cur]     = 1'b0;
				r.granted_address = payload_of(cur);
				r.status          = ffsa_pkg::ST_OK;
				return r;
			end
			if (!seg_linked[cur]) break;
			cur = int'(seg_next[cur]);
		end
		return r;
	endfunction

	// coalesce neighbouring free segments in one pass from the head
	function automatic void coalesce_free();
		int cur, nx, h;
		cur = 0;
		h   = header_len();
		for (int steps = 0; steps < 2 * NUM_SEGS; steps++) begin
			if (!seg_linked[cur]) break;
			nx = int'(seg_next[cur]);
			if (seg_free[cur] && seg_free[nx]) begin
				seg_size[cur]   = 16'(int'(seg_size[cur]) + int'(seg_size[nx]) + h);
				seg_next[cur]   = seg_next[nx];
				seg_linked[cur] = seg_linked[nx];
				seg_used[nx]    = 1'b0;
				seg_linked[nx]  = 1'b0;
				seg_free[nx]    = 1'b0;
				if (seg_count > 0) seg_count--;
			end else begin
				cur = nx;
			end
		end
	endfunction

	function automatic alloc_result_t release_segment(logic [31:0] addr);
		alloc_result_t r;
		int cur;
		cur = 0;
		r.granted_address = '0;
		r.status          = ffsa_pkg::ST_OK;
		if (addr == 32'd0) return r;
		for (int steps = 0; steps < NUM_SEGS; steps++) begin
			if (seg_used[cur] && payload_of(cur) == addr) begin
				seg_free[cur] = 1'b1;
				coalesce_free();
				return r;
			end
			if (!seg_linked[cur]) break;
			cur = int'(seg_next[cur]);
		end
		r.status = ffsa_pkg::ST_NOMATCH;
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		error_count++;
	endtask

	// request beat, with optional typed expectation
	task automatic send_request(input logic [0:0] op, input logic [15:0] size_b,
			input logic [31:0] addr, input bit typed = 0,
			input alloc_result_t typed_result = '0);
		alloc_result_t predicted;
		@(negedge clk);
		while (!steady_mode && $urandom_range(0, 99) < 22) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid           = 1'b1;
		req_ch.operation       = op;
		req_ch.request_size    = size_b;
		req_ch.release_address = addr;
		do @(posedge clk); while (!req_ch.ready);
		if (op == ffsa_pkg::OP_ALLOC) begin
			predicted = allocate_segment(size_b);
			if (predicted.status == ffsa_pkg::ST_OK)
				held_addresses.push_back(predicted.granted_address);
		end else begin
			predicted = release_segment(addr);
		end
		pending_results.push_back(typed ? typed_result : predicted);
	endtask

	// sender goes quiet until every expected result has come
	task automatic wait_results_drained();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// register write while the block is idle
	task automatic write_register(input int index, input logic [31:0] value);
		wait_results_drained();
		@(negedge clk);
		req_ch.valid = 1'b0;
		repeat (8) @(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = 32'(index);
		cfg_ch.data  = value;
		do @(posedge clk); while (!cfg_ch.ready);
		apply_register(index, value);
		held_addresses.delete();
		freed_addresses.delete();
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// one random beat: mostly matched alloc/release traffic, some noise
	task automatic random_request(input int max_size);
		int pick, k;
		logic [31:0] a;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			if (held_addresses.size() != 0 && $urandom_range(0, 99) < 45) begin
				k = $urandom_range(0, held_addresses.size() - 1);
				a = held_addresses[k];
				held_addresses.delete(k);
				freed_addresses.push_back(a);
				send_request(ffsa_pkg::OP_RELEASE, 16'($urandom), a);
			end else if ($urandom_range(0, 99) < 6) begin
				send_request(ffsa_pkg::OP_ALLOC, 16'($urandom_range(0, 1100)), $urandom);
			end else if ($urandom_range(0, 99) < 2) begin
				send_request(ffsa_pkg::OP_ALLOC, 16'($urandom), $urandom);
			end else begin
				send_request(ffsa_pkg::OP_ALLOC, 16'($urandom_range(0, max_size)), $urandom);
			end
		end else if (pick < 76) begin
			send_request(ffsa_pkg::OP_RELEASE, 16'($urandom), 32'd0);
		end else if (pick < 86) begin
			send_request(ffsa_pkg::OP_RELEASE, 16'($urandom), $urandom);
		end else if (pick < 93 && freed_addresses.size() != 0) begin
			a = freed_addresses[$urandom_range(0, freed_addresses.size() - 1)];
			send_request(ffsa_pkg::OP_RELEASE, 16'($urandom), a);
		end else begin
			a = (held_addresses.size() != 0) ?
				held_addresses[$urandom_range(0, held_addresses.size() - 1)] : $urandom;
			send_request(ffsa_pkg::OP_RELEASE, 16'($urandom),
				a + ($urandom_range(0, 1) ? 32'd1 : -32'd1));
		end
	endtask

	// result sink with random back-pressure
	always @(negedge clk) begin
		if (!arst_n)
			rsp_ch.ready <= 1'b0;
		else
			rsp_ch.ready <= steady_mode || ($urandom_range(0, 99) >= 22);
	end

	// compare each result beat with the oldest expectation
	always @(posedge clk) begin
		alloc_result_t exp_r;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result beat with nothing expected");
			end else begin
				exp_r = pending_results.pop_front();
				if (rsp_ch.granted_address !== exp_r.granted_address)
					report_mismatch($sformatf("granted_address %h, wanted %h",
						rsp_ch.granted_address, exp_r.granted_address));
				if (rsp_ch.status !== exp_r.status)
					report_mismatch($sformatf("status %0d, wanted %0d",
						rsp_ch.status, exp_r.status));
			end
		end
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	table_row_t directed_rows[] = '{
		'{ffsa_pkg::OP_ALLOC,   16'd100,  32'h0000_0000, 1'b1, 32'h0020_0018,
			ffsa_pkg::ST_OK},
		'{ffsa_pkg::OP_ALLOC,   16'hFFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000,
			ffsa_pkg::ST_NOMEM},
		'{ffsa_pkg::OP_RELEASE, 16'hFFFF, 32'h0000_0000, 1'b1, 32'h0000_0000,
			ffsa_pkg::ST_OK},
		'{ffsa_pkg::OP_RELEASE, 16'd0,    32'hFFFF_FFFF, 1'b1, 32'h0000_0000,
			ffsa_pkg::ST_NOMATCH},
		'{ffsa_pkg::OP_RELEASE, 16'd0,    32'h0020_0018, 1'b1, 32'h0000_0000,
			ffsa_pkg::ST_OK},
		'{ffsa_pkg::OP_RELEASE, 16'd0,    32'h0020_0018, 1'b1, 32'h0000_0000,
			ffsa_pkg::ST_OK},
		'{ffsa_pkg::OP_ALLOC,   16'd1000, 32'h0000_0000, 1'b1, 32'h0020_0018,
			ffsa_pkg::ST_OK},
		'{ffsa_pkg::OP_ALLOC,   16'd0,    32'h0000_0000, 1'b1, 32'h0000_0000,
			ffsa_pkg::ST_NOMEM},
		'{ffsa_pkg::OP_RELEASE, 16'd0,    32'h0020_0018, 1'b1, 32'h0000_0000,
			ffsa_pkg::ST_OK},
		'{ffsa_pkg::OP_ALLOC,   16'd976,  32'h0000_0000, 1'b1, 32'h0020_0018,
			ffsa_pkg::ST_OK},
		'{ffsa_pkg::OP_RELEASE, 16'd0,    32'h0020_0018, 1'b1, 32'h0000_0000,
			ffsa_pkg::ST_OK},
		'{ffsa_pkg::OP_ALLOC,   16'd975,  32'h0000_0000, 1'b0, 32'h0, ffsa_pkg::ST_OK},
		'{ffsa_pkg::OP_ALLOC,   16'd0,    32'hFFFF_FFFF, 1'b0, 32'h0, ffsa_pkg::ST_OK},
		'{ffsa_pkg::OP_ALLOC,   16'd1,    32'h0000_0000, 1'b0, 32'h0, ffsa_pkg::ST_OK},
		'{ffsa_pkg::OP_RELEASE, 16'd0,    32'h0020_0018, 1'b0, 32'h0, ffsa_pkg::ST_OK},
		'{ffsa_pkg::OP_ALLOC,   16'd0,    32'h0000_0000, 1'b0, 32'h0, ffsa_pkg::ST_OK},
		'{ffsa_pkg::OP_RELEASE, 16'd0,    32'h0020_0409, 1'b0, 32'h0, ffsa_pkg::ST_OK},
		'{ffsa_pkg::OP_RELEASE, 16'd0,    32'h1234_5678, 1'b1, 32'h0000_0000,
			ffsa_pkg::ST_NOMATCH},
		'{ffsa_pkg::OP_ALLOC,   16'h8000, 32'h0000_0000, 1'b1, 32'h0000_0000,
			ffsa_pkg::ST_NOMEM}
	};

	// base, header and largest request size per random phase
	logic [31:0] phase_base[8]   = '{32'h0020_0000, 32'hFFFF_FF00, 32'h0000_0000,
		32'hFFFF_FFFF, 32'h8000_0001, 32'h0001_0000, 32'h7FFF_FFF0, 32'hA5A5_5A5A};
	logic [31:0] phase_header[8] = '{32'h0000_0018, 32'hFFFF_FF01, 32'h0000_00FF,
		32'h1234_5600, 32'h0000_0008, 32'h5A5A_5A80, 32'h0000_0010, 32'h0000_007F};
	int          phase_max[8]    = '{120, 15, 200, 6, 90, 300, 60, 150};

	// stimulus sequence
	initial begin
		alloc_result_t typed_r;
		error_count  = 0;
		steady_mode  = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.operation = ffsa_pkg::OP_ALLOC;
		req_ch.request_size = '0;
		req_ch.release_address = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data  = '0;
		pool_base   = ffsa_pkg::BASE_RESET;
		pool_header = ffsa_pkg::HEADER_RESET;
		restore_single_segment();
		wait (arst_n === 1'b1);

		foreach (directed_rows[i]) begin
			typed_r.granted_address = directed_rows[i].granted_address;
			typed_r.status          = directed_rows[i].status;
			send_request(directed_rows[i].operation, directed_rows[i].request_size,
				directed_rows[i].release_address, directed_rows[i].typed, typed_r);
		end

		for (int p = 0; p < 8; p++) begin
			write_register(ffsa_pkg::CFG_BASE, phase_base[p]);
			write_register(ffsa_pkg::CFG_HEADER, phase_header[p]);
			if (p == 4) write_register(CFG_UNLISTED, $urandom);
			steady_mode = (p == 2);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 1 && n == PHASE_ITEMS / 2) wait_results_drained();
				random_request(phase_max[p]);
			end
		end
		steady_mode = 1'b0;

		@(negedge clk);
		req_ch.valid = 1'b0;
		wait_results_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
